[hw/rtl/rne_pkg.sv]
package rne_pkg;

  localparam int VALUE_W  = 10;
  localparam int SYMBOL_W = 7;
  localparam int STEP_W   = 4;

  // ASCII codes of the numeral letters and the closing newline
  localparam logic [SYMBOL_W-1:0] SYM_M  = 7'd77;
  localparam logic [SYMBOL_W-1:0] SYM_D  = 7'd68;
  localparam logic [SYMBOL_W-1:0] SYM_C  = 7'd67;
  localparam logic [SYMBOL_W-1:0] SYM_L  = 7'd76;
  localparam logic [SYMBOL_W-1:0] SYM_X  = 7'd88;
  localparam logic [SYMBOL_W-1:0] SYM_V  = 7'd86;
  localparam logic [SYMBOL_W-1:0] SYM_I  = 7'd73;
  localparam logic [SYMBOL_W-1:0] SYM_NL = 7'd10;

  typedef enum logic {
    OP_TEST,  // emit while the remainder reaches the row amount
    OP_END    // emit the newline and close the run
  } rne_op_t;

  // One control word of the sequencer program
  typedef struct packed {
    rne_op_t             op;
    logic [VALUE_W-1:0]  amount;
    logic [SYMBOL_W-1:0] sym_a;
    logic [SYMBOL_W-1:0] sym_b;
    logic                pair;  // two-letter subtractive pattern
    logic                rpt;   // row may be taken again
  } rne_uword_t;

  // Greedy program: one row per numeral value, largest first
  function automatic rne_uword_t rne_ucode(input logic [STEP_W-1:0] step);
    rne_uword_t w;
    w = '{op: OP_END, amount: '0, sym_a: SYM_NL, sym_b: SYM_NL, pair: 1'b0, rpt: 1'b0};
    unique case (step)
      4'd0:  w = '{OP_TEST, 10'd1000, SYM_M, SYM_M, 1'b0, 1'b1};
      4'd1:  w = '{OP_TEST, 10'd900,  SYM_C, SYM_M, 1'b1, 1'b0};
      4'd2:  w = '{OP_TEST, 10'd500,  SYM_D, SYM_D, 1'b0, 1'b0};
      4'd3:  w = '{OP_TEST, 10'd400,  SYM_C, SYM_D, 1'b1, 1'b0};
      4'd4:  w = '{OP_TEST, 10'd100,  SYM_C, SYM_C, 1'b0, 1'b1};
      4'd5:  w = '{OP_TEST, 10'd90,   SYM_X, SYM_C, 1'b1, 1'b0};
      4'd6:  w = '{OP_TEST, 10'd50,   SYM_L, SYM_L, 1'b0, 1'b0};
      4'd7:  w = '{OP_TEST, 10'd40,   SYM_X, SYM_L, 1'b1, 1'b0};
      4'd8:  w = '{OP_TEST, 10'd10,   SYM_X, SYM_X, 1'b0, 1'b1};
      4'd9:  w = '{OP_TEST, 10'd9,    SYM_I, SYM_X, 1'b1, 1'b0};
      4'd10: w = '{OP_TEST, 10'd5,    SYM_V, SYM_V, 1'b0, 1'b0};
      4'd11: w = '{OP_TEST, 10'd4,    SYM_I, SYM_V, 1'b1, 1'b0};
      4'd12: w = '{OP_TEST, 10'd1,    SYM_I, SYM_I, 1'b0, 1'b1};
      default: w = '{OP_END, 10'd0,   SYM_NL, SYM_NL, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/rne_if.sv]
interface rne_in_if import rne_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if import rne_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

[hw/rtl/roman_numeral_encoder.sv]
// Channel   Dir  Payload                 Beat
// number    in   value[9:0]              integer to convert
// numeral   out  symbol[6:0], last       one ASCII letter, newline with last
//
// One item holds the sequencer while it takes the number, while it emits each letter,
// on each program row that ends on a miss and while it emits the newline.
// The sequencer issues one control word per cycle while the output does not stall.
// Reset (rst, synchronous) empties the output register and idles the sequencer.
// An output stall freezes the sequencer; the next number is taken while the
// closing newline still waits in the output register.
module roman_numeral_encoder import rne_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rne_in_if.sink    number,
  rne_out_if.source numeral
);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic                half;
  logic [VALUE_W-1:0]  rem;
  logic                ovalid;
  logic [SYMBOL_W-1:0] osym;
  logic                olast;

  rne_uword_t cw;
  logic       hit;
  logic       can_emit;

  // Decode the current control word
  assign cw       = rne_ucode(step);
  assign hit      = (rem >= cw.amount);
  assign can_emit = !ovalid || numeral.ready;

  assign number.ready   = !busy;
  assign numeral.valid  = ovalid;
  assign numeral.symbol = osym;
  assign numeral.last   = olast;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (number.valid && !busy) begin
        busy <= 1'b1;
        rem  <= number.value;
        step <= '0;
        half <= 1'b0;
        if (numeral.ready) begin
          ovalid <= 1'b0;
        end
      end else if (busy && can_emit) begin
        unique case (cw.op)
          OP_END: begin
            ovalid <= 1'b1;
            osym   <= SYM_NL;
            olast  <= 1'b1;
            busy   <= 1'b0;
          end
          OP_TEST: begin
            if (hit) begin
              ovalid <= 1'b1;
              olast  <= 1'b0;
              if (cw.pair && !half) begin
                osym <= cw.sym_a;
                half <= 1'b1;
              end else begin
                osym <= cw.pair ? cw.sym_b : cw.sym_a;
                half <= 1'b0;
                rem  <= rem - cw.amount;
                if (!cw.rpt) begin
                  step <= step + STEP_W'(1);
                end
              end
            end else begin
              // skip a row the remainder does not reach
              ovalid <= 1'b0;
              step   <= step + STEP_W'(1);
            end
          end
          default: begin
            ovalid <= 1'b0;
            busy   <= 1'b0;
          end
        endcase
      end else if (numeral.ready) begin
        // drop a beat taken while the sequencer is idle
        ovalid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/rne_checker.sv]
module rne_checker import rne_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SYMBOL_W-1:0] out_symbol,
  input logic                out_last
);

  logic [1:0] pending;
  logic       in_acc;
  logic       run_done;

  assign in_acc   = in_valid && in_ready;
  assign run_done = out_valid && out_ready && out_last;

  // Count numbers taken whose newline has not left yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, run_done};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("numeral beat changed under stall");

  a_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_symbol == SYM_M) || (out_symbol == SYM_D) || (out_symbol == SYM_C) ||
                  (out_symbol == SYM_L) || (out_symbol == SYM_X) || (out_symbol == SYM_V) ||
                  (out_symbol == SYM_I) || (out_symbol == SYM_NL))
    else $error("illegal numeral symbol");

  a_last_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_symbol == SYM_NL)))
    else $error("last mark not on newline");

  a_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_acc |-> pending != 2'd2) and (out_valid |-> pending != 2'd0))
    else $error("runs overlap or beat without a number");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (number.valid),
  .in_ready   (number.ready),
  .out_valid  (numeral.valid),
  .out_ready  (numeral.ready),
  .out_symbol (numeral.symbol),
  .out_last   (numeral.last)
);

[verif/rne_checker.sv]
`timescale 1ns / 1ps

module rne_scoreboard import rne_pkg::*; (
  input  logic clk,
  input  logic rst,
  rne_in_if    number,
  rne_out_if   numeral,
  output int   mismatches,
  output int   outstanding
);

  // One letter of a numeral still to come, tagged with the number it spells
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } numeral_letter_t;

  numeral_letter_t letters_due[$];

  task automatic flag_mismatch(input string what);
    $display("[%0t] numeral check: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void push_letter(input logic [VALUE_W-1:0] value,
                                      input logic [SYMBOL_W-1:0] symbol,
                                      input logic last);
    numeral_letter_t letter;
    letter.value  = value;
    letter.symbol = symbol;
    letter.last   = last;
    letters_due.push_back(letter);
  endfunction

  // Write one decimal digit with the one, five and ten letters of its place
  function automatic void spell_digit(input logic [VALUE_W-1:0] value, input int digit,
                                      input logic [SYMBOL_W-1:0] one, five, ten);
    int ones;
    ones = digit;
    if (digit == 9) begin
      push_letter(value, one, 1'b0);
      push_letter(value, ten, 1'b0);
    end else if (digit == 4) begin
      push_letter(value, one, 1'b0);
      push_letter(value, five, 1'b0);
    end else begin
      if (digit >= 5) begin
        push_letter(value, five, 1'b0);
        ones = digit - 5;
      end
      repeat (ones) push_letter(value, one, 1'b0);
    end
  endfunction

  // Queue the whole numeral of one number, closed by the newline
  function automatic void spell_numeral(input logic [VALUE_W-1:0] value);
    int whole;
    int rest;
    whole = int'(value);
    rest  = whole % 1000;
    repeat (whole / 1000) push_letter(value, SYM_M, 1'b0);
    spell_digit(value, rest / 100, SYM_C, SYM_D, SYM_M);
    spell_digit(value, (rest / 10) % 10, SYM_X, SYM_L, SYM_C);
    spell_digit(value, rest % 10, SYM_I, SYM_V, SYM_X);
    push_letter(value, SYM_NL, 1'b1);
  endfunction

  // Compare output beats first, then queue the letters of a newly taken number
  always @(posedge clk) begin
    numeral_letter_t due;
    if (rst) begin
      letters_due.delete();
      mismatches = 0;
    end else begin
      if (numeral.valid && numeral.ready) begin
        if (letters_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat: symbol %0d last %0b",
                                  numeral.symbol, numeral.last));
        end else begin
          due = letters_due.pop_front();
          if (numeral.symbol !== due.symbol)
            flag_mismatch($sformatf("value %0d: symbol %0d, want %0d",
                                    due.value, numeral.symbol, due.symbol));
          if (numeral.last !== due.last)
            flag_mismatch($sformatf("value %0d: last %0b, want %0b",
                                    due.value, numeral.last, due.last));
        end
      end
      if (number.valid && number.ready)
        spell_numeral(number.value);
    end
    outstanding = letters_due.size();
  end

endmodule

[verif/tb_roman_numeral_encoder.sv]
`timescale 1ns / 1ps

module tb_roman_numeral_encoder import rne_pkg::*; ();

  localparam int RANDOM_NUMBERS = 305;
  localparam int DRAIN_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  bit   calm;

  // Extremes, every subtractive pattern, zero and the 511/512 bit boundary
  int directed_values[25] = '{0, 1000, 1, 4, 5, 9, 10, 40, 50, 90, 100, 400, 500,
                              900, 999, 888, 3, 8, 49, 94, 444, 511, 512, 777, 388};
  int heavy_digits[3] = '{4, 8, 9};

  rne_in_if  number ();
  rne_out_if numeral ();

  roman_numeral_encoder DUT (
    .clk     (clk),
    .rst     (rst),
    .number  (number),
    .numeral (numeral)
  );

  rne_scoreboard checker_inst (
    .clk         (clk),
    .rst         (rst),
    .number      (number),
    .numeral     (numeral),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    return calm ? 0 : int'($urandom_range(0, 15));
  endfunction

  // Hold valid low for the gap, then present the number until it is taken
  task automatic send_number(input logic [VALUE_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      number.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    number.valid <= 1'b1;
    number.value <= value;
    @(posedge clk);
    while (!number.ready) @(posedge clk);
  endtask

  // Stall the numeral channel at random before each beat
  initial begin
    int stall;
    numeral.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        numeral.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      numeral.ready <= 1'b1;
      @(posedge clk);
      while (!numeral.valid) @(posedge clk);
    end
  end

  initial begin
    logic [VALUE_W-1:0] value;
    int kind;
    calm = 1'b0;
    rst <= 1'b1;
    number.valid <= 1'b0;
    number.value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[i])
      send_number(VALUE_W'(directed_values[i]));

    // Mix uniform numbers with long numerals and the range ends
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      if (n % 40 == 0)
        calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0)
        value = $urandom_range(0, 1) ? 10'd1000 : 10'd0;
      else if (kind <= 2)
        value = VALUE_W'(heavy_digits[$urandom_range(0, 2)] * 100
                       + heavy_digits[$urandom_range(0, 2)] * 10
                       + heavy_digits[$urandom_range(0, 2)]);
      else
        value = VALUE_W'($urandom_range(0, 1000));
      send_number(value);
    end
    number.valid <= 1'b0;
    calm = 1'b0;

    // Drain the numeral channel, then let the sequencer settle
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("roman_numeral_encoder: match");
    end else begin
      $display("roman_numeral_encoder: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("roman_numeral_encoder: mismatch");
    $finish;
  end

endmodule

[files.f]
hw/rtl/rne_pkg.sv
hw/rtl/rne_if.sv
hw/rtl/roman_numeral_encoder.sv
hw/rtl/rne_checker.sv
verif/rne_checker.sv
verif/tb_roman_numeral_encoder.sv
